### hw/rtl/ttws_pkg.sv
`timescale 1ns / 1ps
// package for the text terminal engine: transaction structs, decoded op codes
// and character/cell constants; no dependencies

package ttws_pkg;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] lines_ago;
    } req_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic        cell_valid;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [7:0]  lines_stored;
        logic        scrolled;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_NEWLINE,
        OP_TAB,
        OP_RETURN,
        OP_BACKSPACE,
        OP_CHAR,
        OP_READ_SCREEN,
        OP_READ_HIST,
        OP_SET_CURSOR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] char_code;
        logic [7:0] row;
        logic [7:0] col;
        logic [7:0] lines_ago;
        logic       row_ok;
        logic       col_ok;
    } cmd_t;

    localparam logic [1:0] FUNC_PUT         = 2'd0;
    localparam logic [1:0] FUNC_READ_SCREEN = 2'd1;
    localparam logic [1:0] FUNC_READ_HIST   = 2'd2;
    localparam logic [1:0] FUNC_SET_CURSOR  = 2'd3;

    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_TAB       = 8'd9;
    localparam logic [7:0] CHAR_RETURN    = 8'd13;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;

    localparam logic [15:0] RESET_CELL       = 16'h0720;
    localparam logic [7:0]  TEXT_COLOR_RESET = 8'd7;
    localparam int          TAB_STOP         = 8;

endpackage

### hw/rtl/ttws_front.sv
`timescale 1ns / 1ps
// front end: takes request transactions, decodes them into commands and
// holds them in a two-entry queue for the back end; uses ttws_pkg

module ttws_front #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ttws_pkg::req_t req,
    input  logic          push,
    output logic          full,
    output ttws_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_pop
);
    import ttws_pkg::*;

    localparam logic [7:0] COLS_L = 8'(COLS);
    localparam logic [7:0] ROWS_L = 8'(ROWS);

    cmd_t       cls;
    cmd_t       entry_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       push_ok, pop_ok;

    always_comb
    begin
        cls.char_code  = req.char_code;
        cls.row        = req.row;
        cls.col        = req.col;
        cls.lines_ago  = req.lines_ago;
        cls.row_ok     = req.row < ROWS_L;
        cls.col_ok     = req.col < COLS_L;
        case (req.func)
            FUNC_PUT:
            begin
                case (req.char_code)
                    CHAR_NEWLINE:   cls.op = OP_NEWLINE;
                    CHAR_TAB:       cls.op = OP_TAB;
                    CHAR_RETURN:    cls.op = OP_RETURN;
                    CHAR_BACKSPACE: cls.op = OP_BACKSPACE;
                    default:        cls.op = OP_CHAR;
                endcase
            end
            FUNC_READ_SCREEN: cls.op = OP_READ_SCREEN;
            FUNC_READ_HIST:   cls.op = OP_READ_HIST;
            default:          cls.op = OP_SET_CURSOR;
        endcase
    end

    assign full      = cnt_reg == 2'd2;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign pop_ok    = cmd_pop && cmd_valid;

    always_comb
    begin
        cnt_next    = cnt_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_ok)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop_ok)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hw/rtl/ttws_back.sv
`timescale 1ns / 1ps
// back end: cursor, screen ring of rows, scrollback ring and the result
// register; executes one command at a time; uses ttws_pkg

module ttws_back #(
    parameter int COLS          = 80,
    parameter int ROWS          = 25,
    parameter int HISTORY_LINES = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata,
    input  ttws_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output ttws_pkg::rsp_t rsp,
    output logic           empty,
    input  logic           pop
);
    import ttws_pkg::*;

    localparam int RW  = $clog2(ROWS);
    localparam int CRW = $clog2(COLS);
    localparam int CW  = $clog2(COLS + TAB_STOP);
    localparam int HW  = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int NW  = $clog2(HISTORY_LINES + 1);
    localparam int IW  = ((NW > 8) ? NW : 8) + 1;
    localparam int SN  = ROWS * COLS;
    localparam int HN  = HISTORY_LINES * COLS;
    localparam int SAW = $clog2(SN);
    localparam int HAW = $clog2(HN);
    localparam int LW  = (RW > HW) ? RW : HW;
    localparam int AW  = (SAW > HAW) ? SAW : HAW;
    localparam int SCW = $clog2(COLS + 1);

    localparam logic [RW:0] ROWS_C = (RW + 1)'(ROWS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_SCROLL
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [LW-1:0]      line_reg, line_next;
    logic               hist_ok_reg, hist_ok_next;
    logic [RW-1:0]      cur_row_reg, cur_row_next;
    logic [CRW-1:0]     cur_col_reg, cur_col_next;
    logic [RW-1:0]      top_reg, top_next;
    logic [SAW-1:0]     top_base_reg, top_base_next;
    logic [HW-1:0]      head_reg, head_next;
    logic [HAW-1:0]     head_base_reg, head_base_next;
    logic [NW-1:0]      count_reg, count_next;
    logic [SAW-1:0]     clr_reg, clr_next;
    logic [SCW-1:0]     sc_reg, sc_next;
    logic [SCW-1:0]     sc_prev;
    logic [7:0]         text_color_reg;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg;
    rsp_t               result;
    logic               result_set;
    logic               res_valid;
    logic [15:0]        res_value;
    logic               res_scrolled;

    // physical row and history line lookup for the incoming command
    logic [RW-1:0]      row_sel, prow;
    logic [RW:0]        psum;
    logic [IW-1:0]      hsum;
    logic [HW-1:0]      hidx;
    logic               hist_ok;

    logic [7:0]         col_sel;
    logic [AW-1:0]      exec_addr;

    logic [CW-1:0]      ccol, ncol;
    logic               adv_nl;
    logic [RW:0]        nrow;
    logic               need_scroll;
    logic [RW-1:0]      row_after, row_set;
    logic [CRW-1:0]     col_set;

    logic [15:0]        screen_mem [SN];
    logic [15:0]        hist_mem [HN];
    logic               scr_we, scr_re, hist_we, hist_re;
    logic [SAW-1:0]     scr_waddr, scr_raddr;
    logic [HAW-1:0]     hist_waddr, hist_raddr;
    logic [15:0]        scr_wdata;
    logic [15:0]        scr_rdata_reg, hist_rdata_reg;

    assign empty = !out_valid_reg;
    assign rsp   = out_reg;

    always_comb
    begin
        row_sel = (cmd.op == OP_READ_SCREEN) ? cmd.row[RW-1:0] : cur_row_reg;
        psum    = {1'b0, row_sel} + {1'b0, top_reg};
        prow    = (psum >= ROWS_C) ? RW'(psum - ROWS_C) : psum[RW-1:0];
        hsum    = IW'(head_reg) + IW'(HISTORY_LINES) - IW'(cmd.lines_ago);
        hidx    = (hsum >= IW'(HISTORY_LINES)) ? HW'(hsum - IW'(HISTORY_LINES))
                                               : HW'(hsum);
        hist_ok = (cmd.lines_ago != 8'd0)
                  && (IW'(cmd.lines_ago) <= IW'(count_reg)) && cmd.col_ok;
    end

    always_comb
    begin
        col_sel   = (cmd_reg.op == OP_CHAR) ? 8'(cur_col_reg) : cmd_reg.col;
        exec_addr = AW'(line_reg) * AW'(COLS) + AW'(col_sel);
    end

    // cursor movement for put commands
    always_comb
    begin
        ccol   = CW'(cur_col_reg);
        ncol   = ccol;
        adv_nl = 1'b0;
        case (cmd_reg.op)
            OP_NEWLINE:
            begin
                ncol   = '0;
                adv_nl = 1'b1;
            end
            OP_TAB:       ncol = (ccol + CW'(TAB_STOP)) & ~CW'(TAB_STOP - 1);
            OP_RETURN:    ncol = '0;
            OP_BACKSPACE:
            begin
                if (ccol != '0)
                begin
                    ncol = ccol - CW'(1);
                end
            end
            OP_CHAR:      ncol = ccol + CW'(1);
            default:      ncol = ccol;
        endcase
        if (ncol >= CW'(COLS))
        begin
            ncol   = '0;
            adv_nl = 1'b1;
        end
        nrow        = {1'b0, cur_row_reg} + (RW + 1)'(adv_nl);
        need_scroll = nrow >= ROWS_C;
        row_after   = need_scroll ? RW'(ROWS - 1) : nrow[RW-1:0];
        col_set     = cmd_reg.col_ok ? CRW'(cmd_reg.col) : cur_col_reg;
        row_set     = cmd_reg.row_ok ? RW'(cmd_reg.row) : cur_row_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        line_next      = line_reg;
        hist_ok_next   = hist_ok_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        top_base_next  = top_base_reg;
        head_next      = head_reg;
        head_base_next = head_base_reg;
        count_next     = count_reg;
        clr_next       = clr_reg;
        sc_next        = sc_reg;
        out_valid_next = out_valid_reg;
        cmd_pop        = 1'b0;
        result_set     = 1'b0;
        res_valid      = 1'b0;
        res_value      = 16'd0;
        res_scrolled   = 1'b0;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + SAW'(1);
                if (clr_reg == SAW'(SN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid && (!out_valid_reg || pop))
                begin
                    cmd_pop      = 1'b1;
                    cmd_next     = cmd;
                    line_next    = (cmd.op == OP_READ_HIST) ? LW'(hidx) : LW'(prow);
                    hist_ok_next = hist_ok;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_READ_SCREEN, OP_READ_HIST: state_next = S_RDATA;
                    OP_SET_CURSOR:
                    begin
                        cur_col_next = col_set;
                        cur_row_next = row_set;
                        result_set   = 1'b1;
                        state_next   = S_IDLE;
                    end
                    default:
                    begin
                        cur_col_next = CRW'(ncol);
                        cur_row_next = row_after;
                        if (need_scroll)
                        begin
                            sc_next    = '0;
                            state_next = S_SCROLL;
                        end
                        else
                        begin
                            result_set = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_RDATA:
            begin
                if (cmd_reg.op == OP_READ_SCREEN)
                begin
                    res_valid = cmd_reg.row_ok && cmd_reg.col_ok;
                    res_value = res_valid ? scr_rdata_reg : 16'd0;
                end
                else
                begin
                    res_valid = hist_ok_reg;
                    res_value = hist_ok_reg ? hist_rdata_reg : 16'd0;
                end
                result_set = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                sc_next = sc_reg + SCW'(1);
                if (sc_reg == SCW'(COLS))
                begin
                    // old top row now serves as the blank bottom row
                    top_next       = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
                    top_base_next  = (top_base_reg == SAW'(SN - COLS)) ? '0
                                     : top_base_reg + SAW'(COLS);
                    head_next      = (head_reg == HW'(HISTORY_LINES - 1)) ? '0
                                     : head_reg + HW'(1);
                    head_base_next = (head_base_reg == HAW'(HN - COLS)) ? '0
                                     : head_base_reg + HAW'(COLS);
                    if (count_reg != NW'(HISTORY_LINES))
                    begin
                        count_next = count_reg + NW'(1);
                    end
                    res_scrolled = 1'b1;
                    result_set   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (result_set)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        result.cell_value   = res_value;
        result.cell_valid   = res_valid;
        result.cursor_row   = 5'(cur_row_next);
        result.cursor_col   = 7'(cur_col_next);
        result.lines_stored = 8'(count_next);
        result.scrolled     = res_scrolled;
    end

    // memory port selection
    always_comb
    begin
        sc_prev    = sc_reg - SCW'(1);
        scr_we     = 1'b0;
        scr_re     = 1'b0;
        hist_we    = 1'b0;
        hist_re    = 1'b0;
        scr_waddr  = clr_reg;
        scr_wdata  = RESET_CELL;
        scr_raddr  = exec_addr[SAW-1:0];
        hist_waddr = head_base_reg + HAW'(sc_prev);
        hist_raddr = exec_addr[HAW-1:0];
        case (state_reg)
            S_CLEAR: scr_we = 1'b1;
            S_EXEC:
            begin
                scr_waddr = exec_addr[SAW-1:0];
                scr_wdata = {text_color_reg, cmd_reg.char_code};
                scr_we    = cmd_reg.op == OP_CHAR;
                scr_re    = (cmd_reg.op == OP_READ_SCREEN)
                            && cmd_reg.row_ok && cmd_reg.col_ok;
                hist_re   = (cmd_reg.op == OP_READ_HIST) && hist_ok_reg;
            end
            S_SCROLL:
            begin
                // read one column ahead of the copy and blank writes
                scr_raddr = top_base_reg + SAW'(sc_reg);
                scr_re    = sc_reg < SCW'(COLS);
                scr_waddr = top_base_reg + SAW'(sc_prev);
                scr_wdata = {text_color_reg, CHAR_BLANK};
                scr_we    = sc_reg != '0;
                hist_we   = sc_reg != '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (scr_we)
        begin
            screen_mem[scr_waddr] <= scr_wdata;
        end
        if (scr_re)
        begin
            scr_rdata_reg <= screen_mem[scr_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= scr_rdata_reg;
        end
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cmd_reg        <= '0;
            line_reg       <= '0;
            hist_ok_reg    <= 1'b0;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            top_base_reg   <= '0;
            head_reg       <= '0;
            head_base_reg  <= '0;
            count_reg      <= '0;
            clr_reg        <= '0;
            sc_reg         <= '0;
            text_color_reg <= TEXT_COLOR_RESET;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            line_reg       <= line_next;
            hist_ok_reg    <= hist_ok_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            top_base_reg   <= top_base_next;
            head_reg       <= head_next;
            head_base_reg  <= head_base_next;
            count_reg      <= count_next;
            clr_reg        <= clr_next;
            sc_reg         <= sc_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                text_color_reg <= cfg_wdata;
            end
            if (result_set)
            begin
                out_reg <= result;
            end
        end
    end

endmodule

### hw/rtl/text_terminal_with_scrollback.sv
`timescale 1ns / 1ps
// text terminal engine top level; instantiates ttws_front and ttws_back
// the back end executes one request at a time and takes the next only after
// its result is set; a put that scrolls also copies the top row into the
// scrollback ring and blanks it as the new bottom row before its result is set
// after reset a clearing pass writes ROWS*COLS blank cells (2000 by default);
// requests queue (two deep) but no result appears until the pass ends

module text_terminal_with_scrollback #(
    parameter int COLS          = 80,
    parameter int ROWS          = 25,
    parameter int HISTORY_LINES = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ttws_pkg::req_t req,
    input  logic           push,
    output logic           full,
    output ttws_pkg::rsp_t rsp,
    output logic           empty,
    input  logic           pop,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata
);
    import ttws_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    ttws_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    ttws_back #(
        .COLS          (COLS),
        .ROWS          (ROWS),
        .HISTORY_LINES (HISTORY_LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### dv/ttws_response_checker.sv
`timescale 1ns / 1ps
// response checker for the text terminal engine: mirrors screen, cursor and
// scrollback ring, predicts each response and compares it; depends on ttws_pkg

module ttws_response_checker #(
    parameter int COLS          = 80,
    parameter int ROWS          = 25,
    parameter int HISTORY_LINES = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ttws_pkg::req_t req,
    input  logic           push,
    input  logic           full,
    input  ttws_pkg::rsp_t rsp,
    input  logic           empty,
    input  logic           pop,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata,
    output int             fail_count,
    output int             outstanding,
    output int             scroll_total
);

    import ttws_pkg::*;

    logic [15:0] screen_mirror [ROWS*COLS];
    logic [15:0] ring_mirror [HISTORY_LINES*COLS];
    logic [7:0]  color_now;
    int          cursor_r;
    int          cursor_c;
    int          ring_head;
    int          ring_fill;
    int          mismatches;
    int          scrolls;
    rsp_t        pending_rsp [$];
    rsp_t        predicted;
    rsp_t        want;
    int          k;

    assign fail_count   = mismatches;
    assign scroll_total = scrolls;

    task automatic note_failure(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic logic [15:0] colored(input logic [7:0] ch);
        return {color_now, ch};
    endfunction

    // top row goes into the ring, rows move up, bottom row blanked in the current color
    task automatic scroll_up();
        int x;
        for (x = 0; x < COLS; x++)
            ring_mirror[ring_head*COLS + x] = screen_mirror[x];
        ring_head = (ring_head + 1) % HISTORY_LINES;
        if (ring_fill < HISTORY_LINES)
            ring_fill++;
        for (x = 0; x < (ROWS - 1) * COLS; x++)
            screen_mirror[x] = screen_mirror[x + COLS];
        for (x = 0; x < COLS; x++)
            screen_mirror[(ROWS - 1) * COLS + x] = colored(CHAR_BLANK);
        cursor_r = ROWS - 1;
        scrolls++;
    endtask

    task automatic apply_request(input req_t r, output rsp_t res);
        logic rolled;
        int   spot;
        res    = '0;
        rolled = 1'b0;
        case (r.func)
            FUNC_PUT:
            begin
                case (r.char_code)
                    CHAR_NEWLINE:
                    begin
                        cursor_c = 0;
                        cursor_r++;
                    end
                    CHAR_TAB:       cursor_c = (cursor_c + TAB_STOP) & ~(TAB_STOP - 1);
                    CHAR_RETURN:    cursor_c = 0;
                    CHAR_BACKSPACE: if (cursor_c > 0) cursor_c--;
                    default:
                    begin
                        screen_mirror[cursor_r*COLS + cursor_c] = colored(r.char_code);
                        cursor_c++;
                    end
                endcase
                if (cursor_c >= COLS)
                begin
                    cursor_c = 0;
                    cursor_r++;
                end
                if (cursor_r >= ROWS)
                begin
                    scroll_up();
                    rolled = 1'b1;
                end
            end
            FUNC_READ_SCREEN:
            begin
                if (r.row < ROWS && r.col < COLS)
                begin
                    res.cell_value = screen_mirror[r.row*COLS + r.col];
                    res.cell_valid = 1'b1;
                end
            end
            FUNC_READ_HIST:
            begin
                if (r.lines_ago >= 1 && r.lines_ago <= ring_fill && r.col < COLS)
                begin
                    spot = (ring_head + HISTORY_LINES - r.lines_ago) % HISTORY_LINES;
                    res.cell_value = ring_mirror[spot*COLS + r.col];
                    res.cell_valid = 1'b1;
                end
            end
            FUNC_SET_CURSOR:
            begin
                // row and column are range-checked independently
                if (r.col < COLS)
                    cursor_c = r.col;
                if (r.row < ROWS)
                    cursor_r = r.row;
            end
            default: ;
        endcase
        res.cursor_row   = 5'(cursor_r);
        res.cursor_col   = 7'(cursor_c);
        res.lines_stored = 8'(ring_fill);
        res.scrolled     = rolled;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < ROWS * COLS; k++)
                screen_mirror[k] = RESET_CELL;
            color_now  = TEXT_COLOR_RESET;
            cursor_r   = 0;
            cursor_c   = 0;
            ring_head  = 0;
            ring_fill  = 0;
            mismatches = 0;
            scrolls    = 0;
            pending_rsp.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
                color_now = cfg_wdata;
            if (push && !full)
            begin
                apply_request(req, predicted);
                pending_rsp.push_back(predicted);
            end
            if (pop && !empty)
            begin
                if (pending_rsp.size() == 0)
                    note_failure($sformatf("response %h with no request waiting", rsp));
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.cell_value !== want.cell_value)
                        note_failure($sformatf("cell_value %h, expected %h",
                                               rsp.cell_value, want.cell_value));
                    if (rsp.cell_valid !== want.cell_valid)
                        note_failure($sformatf("cell_valid %b, expected %b",
                                               rsp.cell_valid, want.cell_valid));
                    if (rsp.cursor_row !== want.cursor_row)
                        note_failure($sformatf("cursor_row %0d, expected %0d",
                                               rsp.cursor_row, want.cursor_row));
                    if (rsp.cursor_col !== want.cursor_col)
                        note_failure($sformatf("cursor_col %0d, expected %0d",
                                               rsp.cursor_col, want.cursor_col));
                    if (rsp.lines_stored !== want.lines_stored)
                        note_failure($sformatf("lines_stored %0d, expected %0d",
                                               rsp.lines_stored, want.lines_stored));
                    if (rsp.scrolled !== want.scrolled)
                        note_failure($sformatf("scrolled %b, expected %b",
                                               rsp.scrolled, want.scrolled));
                end
            end
            outstanding <= pending_rsp.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// top of the text terminal engine bench: clock, reset, request and response
// traffic, color writes and verdict; depends on ttws_pkg and ttws_response_checker

module testbench;

    import ttws_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int RING_LINES  = 128;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 245;
    localparam int SETTLE      = 100;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_LIMIT  = 20000;

    logic       clk;
    logic       rst_n     = 1'b0;
    req_t       req       = '0;
    logic       push      = 1'b0;
    logic       full;
    rsp_t       rsp;
    logic       empty;
    logic       pop       = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       calm      = 1'b0;

    int fail_count;
    int outstanding;
    int scroll_total;
    int sent;
    int popped;
    int colors;
    int idle_cycles;
    int ph;

    text_terminal_with_scrollback #(
        .COLS          (SCREEN_COLS),
        .ROWS          (SCREEN_ROWS),
        .HISTORY_LINES (RING_LINES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .push      (push),
        .full      (full),
        .rsp       (rsp),
        .empty     (empty),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ttws_response_checker #(
        .COLS          (SCREEN_COLS),
        .ROWS          (SCREEN_ROWS),
        .HISTORY_LINES (RING_LINES)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .push         (push),
        .full         (full),
        .rsp          (rsp),
        .empty        (empty),
        .pop          (pop),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .scroll_total (scroll_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones; none in calm stretches
    function automatic int pick_gap(input logic quiet);
        int p;
        p = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (p < 80)
            return $urandom_range(0, 2);
        if (p < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t make_req(input logic [1:0] f, input logic [7:0] ch,
                                      input logic [7:0] r, input logic [7:0] c,
                                      input logic [7:0] lb);
        req_t t;
        t.func       = f;
        t.char_code  = ch;
        t.row        = r;
        t.col        = c;
        t.lines_ago  = lb;
        return t;
    endfunction

    // random requests, with plenty of newlines among the puts so the ring fills and wraps
    function automatic req_t random_req();
        req_t t;
        int   p;
        t.char_code  = 8'($urandom_range(0, 255));
        t.row        = 8'($urandom_range(0, 255));
        t.col        = 8'($urandom_range(0, 255));
        t.lines_ago  = 8'($urandom_range(0, 128));
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            t.func = FUNC_PUT;
            p = $urandom_range(0, 99);
            if (p < 25)
                t.char_code = CHAR_NEWLINE;
            else if (p < 33)
                t.char_code = CHAR_TAB;
            else if (p < 37)
                t.char_code = CHAR_RETURN;
            else if (p < 41)
                t.char_code = CHAR_BACKSPACE;
        end
        else if (p < 72)
        begin
            t.func = FUNC_READ_SCREEN;
            if ($urandom_range(0, 9) < 8)
            begin
                t.row = 8'($urandom_range(0, SCREEN_ROWS - 1));
                t.col = 8'($urandom_range(0, SCREEN_COLS - 1));
            end
        end
        else if (p < 86)
        begin
            t.func = FUNC_READ_HIST;
            if ($urandom_range(0, 9) < 9)
                t.col = 8'($urandom_range(0, SCREEN_COLS - 1));
            if ($urandom_range(0, 1))
                t.lines_ago = 8'($urandom_range(0, 16));
        end
        else
        begin
            t.func = FUNC_SET_CURSOR;
            if ($urandom_range(0, 9) < 7)
            begin
                t.row = ($urandom_range(0, 2) == 0) ? 8'(SCREEN_ROWS - 1)
                                                    : 8'($urandom_range(0, SCREEN_ROWS - 1));
                t.col = 8'($urandom_range(0, SCREEN_COLS - 1));
            end
        end
        return t;
    endfunction

    task automatic send_req(input req_t t);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req  <= t;
        push <= 1'b1;
        do @(posedge clk); while (full);
        sent++;
    endtask

    // sender stops until every response is back, then lets the block settle
    task automatic drain_and_settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_color(input logic [7:0] value);
        drain_and_settle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        colors++;
    endtask

    // receiver side, with one long hold so the block backs up into full
    initial
    begin
        int gap;
        popped = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = pick_gap(calm);
            if (popped == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            popped++;
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("** text_terminal_with_scrollback: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        sent   = 0;
        colors = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, under the reset color
        send_req(make_req(FUNC_READ_SCREEN, 8'h00, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_READ_SCREEN, 8'h00, 8'd24, 8'd79, 8'd0));
        send_req(make_req(FUNC_READ_SCREEN, 8'h00, 8'd25, 8'd0, 8'd0));
        send_req(make_req(FUNC_READ_SCREEN, 8'h00, 8'd0, 8'd80, 8'd0));
        send_req(make_req(FUNC_READ_HIST, 8'h00, 8'd0, 8'd0, 8'd1));
        send_req(make_req(FUNC_PUT, 8'h41, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, 8'hFF, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, 8'h00, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, CHAR_TAB, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, CHAR_BACKSPACE, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, CHAR_RETURN, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, CHAR_BACKSPACE, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, CHAR_NEWLINE, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_SET_CURSOR, 8'h00, 8'd255, 8'd255, 8'd0));
        send_req(make_req(FUNC_SET_CURSOR, 8'h00, 8'd10, 8'd255, 8'd0));
        send_req(make_req(FUNC_SET_CURSOR, 8'h00, 8'd255, 8'd5, 8'd0));
        // tab from the last column wraps to the next line
        send_req(make_req(FUNC_SET_CURSOR, 8'h00, 8'd3, 8'd79, 8'd0));
        send_req(make_req(FUNC_PUT, CHAR_TAB, 8'd0, 8'd0, 8'd0));
        // char in the bottom-right cell wraps and scrolls
        send_req(make_req(FUNC_SET_CURSOR, 8'h00, 8'd24, 8'd79, 8'd0));
        send_req(make_req(FUNC_PUT, 8'h80, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_READ_HIST, 8'h00, 8'd0, 8'd0, 8'd1));
        send_req(make_req(FUNC_READ_HIST, 8'h00, 8'd0, 8'd80, 8'd1));
        send_req(make_req(FUNC_READ_HIST, 8'h00, 8'd0, 8'd0, 8'd2));
        send_req(make_req(FUNC_READ_HIST, 8'h00, 8'd0, 8'd0, 8'd0));
        send_req(make_req(FUNC_READ_HIST, 8'h00, 8'd0, 8'd0, 8'd128));
        send_req(make_req(FUNC_SET_CURSOR, 8'h00, 8'd24, 8'd0, 8'd0));
        send_req(make_req(FUNC_PUT, CHAR_NEWLINE, 8'd0, 8'd0, 8'd0));

        // random phases, each under its own text color
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       set_color(8'h00);
                1:       set_color(8'hFF);
                default: set_color(8'($urandom_range(1, 254)));
            endcase
            calm <= (ph == 1);
            repeat (PHASE_ITEMS) send_req(random_req());
        end

        drain_and_settle();
        $display("run covered %0d requests and %0d responses over %0d color settings",
                 sent, popped, colors);
        $display("the screen scrolled %0d times, ring depth %0d", scroll_total, RING_LINES);
        if (fail_count == 0 && outstanding == 0)
            $display("** text_terminal_with_scrollback: PASSED **");
        else
            $display("** text_terminal_with_scrollback: FAILED **");
        $finish;
    end

endmodule
